FILE: design/chip8_instruction_core_macros.svh
// Assertion helpers for the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// same-cycle implication
`define C8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/chip8_pkg.sv
package chip8_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int ADDR_W         = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH    = 16;
  localparam int STACK_AW       = $clog2(STACK_DEPTH);
  localparam int SCREEN_W       = 64;
  localparam int SCREEN_H       = 32;
  localparam int ROW_AW         = $clog2(SCREEN_H);
  localparam int COL_AW         = $clog2(SCREEN_W);
  localparam int DROW_W         = 6;
  localparam int CNT_W          = 12;
  localparam int GLYPH_BYTES    = 80;
  localparam int PROG_START_RST = 512;
  localparam int FONT_BASE_RST  = 80;

  // item kinds
  localparam logic [1:0] OPN_EXEC  = 2'd0;
  localparam logic [1:0] OPN_MEMWR = 2'd1;
  localparam logic [1:0] OPN_ROWRD = 2'd2;
  localparam logic [1:0] OPN_MEMRD = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PROGRAM_START = 2'd0;
  localparam logic [1:0] REG_FONT_BASE     = 2'd1;

  // instruction groups (top nibble)
  localparam logic [3:0] OPG_SYS     = 4'h0;
  localparam logic [3:0] OPG_JP      = 4'h1;
  localparam logic [3:0] OPG_CALL    = 4'h2;
  localparam logic [3:0] OPG_SE_IMM  = 4'h3;
  localparam logic [3:0] OPG_SNE_IMM = 4'h4;
  localparam logic [3:0] OPG_SE_REG  = 4'h5;
  localparam logic [3:0] OPG_LD_IMM  = 4'h6;
  localparam logic [3:0] OPG_ADD_IMM = 4'h7;
  localparam logic [3:0] OPG_ALU     = 4'h8;
  localparam logic [3:0] OPG_SNE_REG = 4'h9;
  localparam logic [3:0] OPG_LD_I    = 4'hA;
  localparam logic [3:0] OPG_JP_V0   = 4'hB;
  localparam logic [3:0] OPG_RND     = 4'hC;
  localparam logic [3:0] OPG_DRW     = 4'hD;
  localparam logic [3:0] OPG_KEY     = 4'hE;
  localparam logic [3:0] OPG_MISC    = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MSC_GET_DT   = 8'h07;
  localparam logic [7:0] MSC_WAIT_KEY = 8'h0A;
  localparam logic [7:0] MSC_SET_DT   = 8'h15;
  localparam logic [7:0] MSC_SET_ST   = 8'h18;
  localparam logic [7:0] MSC_ADD_I    = 8'h1E;
  localparam logic [7:0] MSC_FONT     = 8'h29;
  localparam logic [7:0] MSC_BCD      = 8'h33;
  localparam logic [7:0] MSC_STORE    = 8'h55;
  localparam logic [7:0] MSC_LOAD     = 8'h65;

  localparam logic [3:0] VF_IDX = 4'hF;

  localparam logic [7:0] GLYPHS [GLYPH_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_GLYPH, CMD_ACCEPT, CMD_FETCH0, CMD_FETCH1,
    CMD_FETCH2, CMD_RDX, CMD_RDY, CMD_EXEC, CMD_DRAW_RD, CMD_DRAW_WR,
    CMD_DRAW_END, CMD_BCD, CMD_STORE, CMD_LOAD_RD, CMD_LOAD_WR, CMD_TIMERS,
    CMD_MEMWR, CMD_ROWRD, CMD_MEMRD, CMD_MEMRD2
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             cfg_we;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic        draw_stop;
  } dp_stat_t;

endpackage

FILE: design/chip8_ctrl.sv
module chip8_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_operation,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  chip8_pkg::dp_stat_t stat,
  output chip8_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               cfg_ready,
  output logic               out_strobe
);
  import chip8_pkg::*;

  typedef enum logic [21:0] {
    ST_CLEAR    = 22'h000001,
    ST_GLYPH    = 22'h000002,
    ST_IDLE     = 22'h000004,
    ST_FETCH0   = 22'h000008,
    ST_FETCH1   = 22'h000010,
    ST_FETCH2   = 22'h000020,
    ST_RDX      = 22'h000040,
    ST_RDY      = 22'h000080,
    ST_EXEC     = 22'h000100,
    ST_DRAW_RD  = 22'h000200,
    ST_DRAW_WR  = 22'h000400,
    ST_DRAW_END = 22'h000800,
    ST_BCD      = 22'h001000,
    ST_STORE    = 22'h002000,
    ST_LOAD_RD  = 22'h004000,
    ST_LOAD_WR  = 22'h008000,
    ST_TIMERS   = 22'h010000,
    ST_MEMWR    = 22'h020000,
    ST_ROWRD    = 22'h040000,
    ST_MEMRD    = 22'h080000,
    ST_MEMRD2   = 22'h100000,
    ST_RESP     = 22'h200000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       grp, xreg;
  logic [7:0]       kk;
  logic             last_reg;

  assign grp      = stat.opcode[15:12];
  assign xreg     = stat.opcode[11:8];
  assign kk       = stat.opcode[7:0];
  assign last_reg = (cnt_r[3:0] == xreg);

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign out_strobe = (state_r == ST_RESP);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.op     = CMD_NONE;
    cmd.cfg_we = 1'b0;
    cmd.cnt    = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.op  = CMD_CLEAR;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MEM_BYTES - 1)) begin
          state_nxt = ST_GLYPH;
          cnt_nxt   = '0;
        end
      end
      ST_GLYPH: begin
        cmd.op  = CMD_GLYPH;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GLYPH_BYTES - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          cmd.op = CMD_ACCEPT;
          case (in_operation)
            OPN_EXEC:  state_nxt = ST_FETCH0;
            OPN_MEMWR: state_nxt = ST_MEMWR;
            OPN_ROWRD: state_nxt = ST_ROWRD;
            default:   state_nxt = ST_MEMRD;
          endcase
        end else if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (cfg_index == REG_FONT_BASE) state_nxt = ST_GLYPH;
        end
      end
      ST_FETCH0: begin cmd.op = CMD_FETCH0; state_nxt = ST_FETCH1; end
      ST_FETCH1: begin cmd.op = CMD_FETCH1; state_nxt = ST_FETCH2; end
      ST_FETCH2: begin cmd.op = CMD_FETCH2; state_nxt = ST_RDX; end
      ST_RDX:    begin cmd.op = CMD_RDX; state_nxt = ST_RDY; end
      ST_RDY:    begin cmd.op = CMD_RDY; state_nxt = ST_EXEC; end
      ST_EXEC: begin
        cmd.op    = CMD_EXEC;
        cnt_nxt   = '0;
        state_nxt = ST_TIMERS;
        if (grp == OPG_DRW) begin
          state_nxt = (stat.opcode[3:0] == 4'd0) ? ST_DRAW_END : ST_DRAW_RD;
        end else if (grp == OPG_MISC) begin
          case (kk)
            MSC_BCD:   state_nxt = ST_BCD;
            MSC_STORE: state_nxt = ST_STORE;
            MSC_LOAD:  state_nxt = ST_LOAD_RD;
            default:   state_nxt = ST_TIMERS;
          endcase
        end
      end
      ST_DRAW_RD: begin
        cmd.op    = CMD_DRAW_RD;
        state_nxt = stat.draw_stop ? ST_DRAW_END : ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        cmd.op    = CMD_DRAW_WR;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_DRAW_RD;
      end
      ST_DRAW_END: begin cmd.op = CMD_DRAW_END; state_nxt = ST_TIMERS; end
      ST_BCD: begin
        cmd.op  = CMD_BCD;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2)) state_nxt = ST_TIMERS;
      end
      ST_STORE: begin
        cmd.op  = CMD_STORE;
        cnt_nxt = cnt_r + 1'b1;
        if (last_reg) state_nxt = ST_TIMERS;
      end
      ST_LOAD_RD: begin cmd.op = CMD_LOAD_RD; state_nxt = ST_LOAD_WR; end
      ST_LOAD_WR: begin
        cmd.op    = CMD_LOAD_WR;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_reg ? ST_TIMERS : ST_LOAD_RD;
      end
      ST_TIMERS: begin cmd.op = CMD_TIMERS; state_nxt = ST_RESP; end
      ST_MEMWR:  begin cmd.op = CMD_MEMWR; state_nxt = ST_RESP; end
      ST_ROWRD:  begin cmd.op = CMD_ROWRD; state_nxt = ST_RESP; end
      ST_MEMRD:  begin cmd.op = CMD_MEMRD; state_nxt = ST_MEMRD2; end
      ST_MEMRD2: begin cmd.op = CMD_MEMRD2; state_nxt = ST_RESP; end
      ST_RESP:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: design/chip8_dp.sv
module chip8_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  chip8_pkg::dp_cmd_t  cmd,
  output chip8_pkg::dp_stat_t stat,
  input  logic [11:0]         in_address,
  input  logic [7:0]          in_data_byte,
  input  logic [15:0]         in_keys_down,
  input  logic [7:0]          in_random_byte,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  output logic [15:0]         out_executed_opcode,
  output logic [11:0]         out_pc_after,
  output logic [15:0]         out_index_after,
  output logic [63:0]         out_read_value,
  output logic                out_sound_on,
  output logic                out_unknown_op,
  output logic                out_key_waiting
);
  import chip8_pkg::*;

  // main memory, single port, registered read
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic [ADDR_W-1:0]   pc_r, font_r, addr_r;
  logic [15:0]         idx_r, op_r, keys_r;
  logic [STACK_AW-1:0] lvl_r, lvl_up, lvl_dn;
  logic [7:0]          dly_r, snd_r, vx_r, vy_r, data_r, rnd_r;
  logic [63:0]         rdv_r;
  logic                unk_r, kw_r, hit_r;
  logic [7:0]          v_r   [16];
  logic [ADDR_W-1:0]   stk_r [STACK_DEPTH];
  logic [63:0]         frame_r [SCREEN_H];

  logic [3:0]        xr, yr, nr, vrd_idx, kfirst;
  logic [7:0]        kk, vrd;
  logic [ADDR_W-1:0] nnn, iaddr, pc_inc2, pc_dec2;
  logic              key_bit, key_any;
  logic [8:0]        add_s;
  logic [6:0]        glyph_off;

  // drawing
  logic [COL_AW-1:0] x0;
  logic [ROW_AW-1:0] y0;
  logic [DROW_W-1:0] drow, fidx;
  logic              fvalid;
  logic [63:0]       frow, spr_m, keep;

  // decimal digits
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens, ones;

  assign xr  = op_r[11:8];
  assign yr  = op_r[7:4];
  assign nr  = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];

  assign iaddr   = idx_r[ADDR_W-1:0] + cmd.cnt;
  assign pc_inc2 = pc_r + ADDR_W'(2);
  assign pc_dec2 = pc_r - ADDR_W'(2);
  assign lvl_up  = (lvl_r == STACK_AW'(STACK_DEPTH - 1)) ? '0 : lvl_r + 1'b1;
  assign lvl_dn  = (lvl_r == '0) ? STACK_AW'(STACK_DEPTH - 1) : lvl_r - 1'b1;
  assign key_bit = keys_r[vx_r[3:0]];
  assign key_any = |keys_r;
  assign add_s   = {1'b0, vx_r} + {1'b0, vy_r};
  assign glyph_off = {1'b0, vx_r[3:0], 2'b00} + {3'd0, vx_r[3:0]};

  always_comb begin
    kfirst = '0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) kfirst = 4'(k);
    end
  end

  always_comb begin
    case (cmd.op)
      CMD_RDY:   vrd_idx = (op_r[15:12] == OPG_JP_V0) ? 4'd0 : yr;
      CMD_STORE: vrd_idx = cmd.cnt[3:0];
      default:   vrd_idx = xr;
    endcase
  end
  assign vrd = v_r[vrd_idx];

  // sprite row position, read port of the frame shared with row reads
  assign x0     = vx_r[COL_AW-1:0];
  assign y0     = vy_r[ROW_AW-1:0];
  assign drow   = DROW_W'(y0) + DROW_W'(cmd.cnt[3:0]);
  assign fidx   = (cmd.op == CMD_ROWRD) ? DROW_W'(addr_r[4:0]) : drow;
  assign fvalid = (fidx < DROW_W'(SCREEN_H));
  assign frow   = fvalid ? frame_r[fidx[ROW_AW-1:0]] : '0;
  assign keep   = ~64'd0 << (64 - SCREEN_W);
  assign spr_m  = ({mem_q, 56'd0} >> x0) & keep;

  assign stat.opcode    = op_r;
  assign stat.draw_stop = (cmd.cnt[4:0] == {1'b0, nr}) || (drow >= DROW_W'(SCREEN_H));

  // hundreds by compare, tens by reciprocal (exact for every remainder, which stays below 100)
  always_comb begin
    hund = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
    rem  = 7'(vx_r - 8'(hund) * 8'd100);
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'd10);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr_r;
    case (cmd.op)
      CMD_CLEAR: begin mem_we = 1'b1; mem_addr = cmd.cnt; end
      CMD_GLYPH: begin
        mem_we    = 1'b1;
        mem_addr  = font_r + cmd.cnt;
        mem_wdata = GLYPHS[cmd.cnt[6:0]];
      end
      CMD_FETCH0:  mem_addr = pc_r;
      CMD_FETCH1:  mem_addr = pc_r + 1'b1;
      CMD_DRAW_RD: mem_addr = iaddr;
      CMD_LOAD_RD: mem_addr = iaddr;
      CMD_BCD: begin
        mem_we   = 1'b1;
        mem_addr = iaddr;
        case (cmd.cnt[1:0])
          2'd0:    mem_wdata = {6'd0, hund};
          2'd1:    mem_wdata = {4'd0, tens};
          default: mem_wdata = {4'd0, ones};
        endcase
      end
      CMD_STORE: begin mem_we = 1'b1; mem_addr = iaddr; mem_wdata = vrd; end
      CMD_MEMWR: begin mem_we = 1'b1; mem_wdata = data_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= ADDR_W'(PROG_START_RST);
      font_r <= ADDR_W'(FONT_BASE_RST);
      idx_r  <= '0;
      lvl_r  <= '0;
      dly_r  <= '0;
      snd_r  <= '0;
      op_r   <= '0;
      rdv_r  <= '0;
      unk_r  <= 1'b0;
      kw_r   <= 1'b0;
      hit_r  <= 1'b0;
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= '0;
      for (int i = 0; i < SCREEN_H; i++) frame_r[i] <= '0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          REG_PROGRAM_START: pc_r   <= cfg_data;
          REG_FONT_BASE:     font_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        CMD_ACCEPT: begin
          addr_r <= in_address;
          data_r <= in_data_byte;
          keys_r <= in_keys_down;
          rnd_r  <= in_random_byte;
          op_r   <= '0;
          rdv_r  <= '0;
          unk_r  <= 1'b0;
          kw_r   <= 1'b0;
        end
        CMD_FETCH1: op_r[15:8] <= mem_q;
        CMD_FETCH2: begin op_r[7:0] <= mem_q; pc_r <= pc_inc2; end
        CMD_RDX:    vx_r <= vrd;
        CMD_RDY:    vy_r <= vrd;
        CMD_EXEC: begin
          case (op_r[15:12])
            OPG_SYS: begin
              if (op_r == OP_CLS) begin
                for (int i = 0; i < SCREEN_H; i++) frame_r[i] <= '0;
              end else if (op_r == OP_RET) begin
                lvl_r <= lvl_dn;
                pc_r  <= stk_r[lvl_dn];
              end
            end
            OPG_JP: pc_r <= nnn;
            OPG_CALL: begin
              stk_r[lvl_r] <= pc_r;
              lvl_r        <= lvl_up;
              pc_r         <= nnn;
            end
            OPG_SE_IMM:  if (vx_r == kk) pc_r <= pc_inc2;
            OPG_SNE_IMM: if (vx_r != kk) pc_r <= pc_inc2;
            OPG_SE_REG:  if (vx_r == vy_r) pc_r <= pc_inc2;
            OPG_LD_IMM:  v_r[xr] <= kk;
            OPG_ADD_IMM: v_r[xr] <= vx_r + kk;
            OPG_ALU: begin
              // for the flag-setting ops the flag owns VF: their result is dropped when x is VF
              case (nr)
                ALU_MOV: v_r[xr] <= vy_r;
                ALU_OR:  v_r[xr] <= vx_r | vy_r;
                ALU_AND: v_r[xr] <= vx_r & vy_r;
                ALU_XOR: v_r[xr] <= vx_r ^ vy_r;
                ALU_ADD: begin
                  if (xr != VF_IDX) v_r[xr] <= add_s[7:0];
                  v_r[VF_IDX] <= {7'd0, add_s[8]};
                end
                ALU_SUB: begin
                  if (xr != VF_IDX) v_r[xr] <= vx_r - vy_r;
                  v_r[VF_IDX] <= {7'd0, vx_r >= vy_r};
                end
                ALU_SHR: begin
                  if (xr != VF_IDX) v_r[xr] <= vx_r >> 1;
                  v_r[VF_IDX] <= {7'd0, vx_r[0]};
                end
                ALU_SUBN: begin
                  if (xr != VF_IDX) v_r[xr] <= vy_r - vx_r;
                  v_r[VF_IDX] <= {7'd0, vy_r >= vx_r};
                end
                ALU_SHL: begin
                  if (xr != VF_IDX) v_r[xr] <= vx_r << 1;
                  v_r[VF_IDX] <= {7'd0, vx_r[7]};
                end
                default: unk_r <= 1'b1;
              endcase
            end
            OPG_SNE_REG: if (vx_r != vy_r) pc_r <= pc_inc2;
            OPG_LD_I:    idx_r <= {4'd0, nnn};
            OPG_JP_V0:   pc_r <= nnn + ADDR_W'(vy_r);
            OPG_RND:     v_r[xr] <= rnd_r & kk;
            OPG_DRW:     hit_r <= 1'b0;
            OPG_KEY: begin
              if (kk == KEY_SKP) begin
                if (key_bit) pc_r <= pc_inc2;
              end else if (kk == KEY_SKNP) begin
                if (!key_bit) pc_r <= pc_inc2;
              end else begin
                unk_r <= 1'b1;
              end
            end
            OPG_MISC: begin
              case (kk)
                MSC_GET_DT: v_r[xr] <= dly_r;
                MSC_WAIT_KEY: begin
                  if (key_any) begin
                    v_r[xr] <= {4'd0, kfirst};
                  end else begin
                    pc_r <= pc_dec2;
                    kw_r <= 1'b1;
                  end
                end
                MSC_SET_DT: dly_r <= vx_r;
                MSC_SET_ST: snd_r <= vx_r;
                MSC_ADD_I:  idx_r <= idx_r + {8'd0, vx_r};
                MSC_FONT:   idx_r <= {4'd0, font_r} + {9'd0, glyph_off};
                MSC_BCD, MSC_STORE, MSC_LOAD: ;
                default: unk_r <= 1'b1;
              endcase
            end
            default: ;
          endcase
        end
        CMD_DRAW_WR: begin
          frame_r[fidx[ROW_AW-1:0]] <= frow ^ spr_m;
          if (|(frow & spr_m)) hit_r <= 1'b1;
        end
        CMD_DRAW_END: v_r[VF_IDX] <= {7'd0, hit_r};
        CMD_LOAD_WR:  v_r[cmd.cnt[3:0]] <= mem_q;
        CMD_TIMERS: begin
          if (dly_r != '0) dly_r <= dly_r - 1'b1;
          if (snd_r != '0) snd_r <= snd_r - 1'b1;
        end
        CMD_ROWRD:  rdv_r <= frow;
        CMD_MEMRD2: rdv_r <= {56'd0, mem_q};
        default: ;
      endcase
    end
  end

  assign out_executed_opcode = op_r;
  assign out_pc_after        = pc_r;
  assign out_index_after     = idx_r;
  assign out_read_value      = rdv_r;
  assign out_sound_on        = (snd_r != '0);
  assign out_unknown_op      = unk_r;
  assign out_key_waiting     = kw_r;

endmodule

FILE: design/chip8_instruction_core.sv
// CHIP-8 instruction core: one item in, one result strobe out, one item at a time.
// Execute item: opcode fetch, Vx/Vy reads, execute, then a memory read and frame write
// per drawn sprite row plus the VF update, the BCD digit writes, register store writes or
// register load reads and writes; then the timer step and the result strobe. Other items
// do their memory or frame access and strobe; results cannot stall, and the next item is
// taken the cycle after the strobe. Synchronous active-low reset; afterwards busy stays
// high while memory is zeroed and the glyphs are written, and again on a font base write.
module chip8_instruction_core (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  // results
  output logic        out_strobe,
  output logic [15:0] out_executed_opcode,
  output logic [11:0] out_pc_after,
  output logic [15:0] out_index_after,
  output logic [63:0] out_read_value,
  output logic        out_sound_on,
  output logic        out_unknown_op,
  output logic        out_key_waiting,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import chip8_pkg::*;

  dp_cmd_t  cmd;   // per-cycle action from the sequencer
  dp_stat_t stat;  // fetched opcode and draw loop end

  // sequencer: fetch / decode / multi-cycle loops / result strobe
  chip8_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .out_strobe   (out_strobe)
  );

  // machine state: memory, V regs, stack, frame, PC, I, timers
  chip8_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_address          (in_address),
    .in_data_byte        (in_data_byte),
    .in_keys_down        (in_keys_down),
    .in_random_byte      (in_random_byte),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_executed_opcode (out_executed_opcode),
    .out_pc_after        (out_pc_after),
    .out_index_after     (out_index_after),
    .out_read_value      (out_read_value),
    .out_sound_on        (out_sound_on),
    .out_unknown_op      (out_unknown_op),
    .out_key_waiting     (out_key_waiting)
  );

`include "chip8_instruction_core_macros.svh"

  `C8_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `C8_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `C8_ASSERT_NOW(a_strobe_busy, out_strobe, busy, "result strobe with no item in flight")
  `C8_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !busy && !start, "config taken while busy")

endmodule

FILE: dv/tb_chip8_instruction_core.sv
module tb_chip8_instruction_core;
  import chip8_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 160;

  // one input item, one result item
  typedef struct {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
  } item_t;

  typedef struct {
    logic [15:0] opcode;
    logic [11:0] pc;
    logic [15:0] index;
    logic [63:0] readv;
    logic        sound;
    logic        unknown;
    logic        waiting;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [11:0] in_address = '0;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_keys_down = '0;
  logic [7:0]  in_random_byte = '0;
  logic        out_strobe;
  logic [15:0] out_executed_opcode;
  logic [11:0] out_pc_after;
  logic [15:0] out_index_after;
  logic [63:0] out_read_value;
  logic        out_sound_on;
  logic        out_unknown_op;
  logic        out_key_waiting;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  chip8_instruction_core uut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the machine, updated as each item is accepted
  // ---------------------------------------------------------------------------
  logic [11:0] sh_prog_start;
  logic [11:0] sh_font_base;
  logic [7:0]  sh_mem [MEM_BYTES];
  logic [7:0]  sh_v [16];
  logic [15:0] sh_index;
  logic [11:0] sh_pc;
  logic [11:0] sh_stack [STACK_DEPTH];
  logic [3:0]  sh_sp;
  logic [7:0]  sh_delay;
  logic [7:0]  sh_sound;
  logic [63:0] sh_frame [SCREEN_H];

  item_t   pending_items[$];
  result_t expected_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;

  task automatic load_glyphs();
    for (int k = 0; k < GLYPH_BYTES; k++) sh_mem[sh_font_base + 12'(k)] = GLYPHS[k];
  endtask

  task automatic reset_shadow();
    sh_prog_start = 12'(PROG_START_RST);
    sh_font_base = 12'(FONT_BASE_RST);
    foreach (sh_mem[i]) sh_mem[i] = '0;
    load_glyphs();
    foreach (sh_v[i]) sh_v[i] = '0;
    sh_index = '0;
    sh_pc = sh_prog_start;
    foreach (sh_stack[i]) sh_stack[i] = '0;
    sh_sp = '0;
    sh_delay = '0;
    sh_sound = '0;
    foreach (sh_frame[i]) sh_frame[i] = '0;
  endtask

  // XOR a sprite in, clipped at right and bottom; VF gets the collision flag
  function automatic void draw_sprite(logic [5:0] col, logic [4:0] row0, logic [3:0] rows);
    logic        hit;
    logic [63:0] pix;
    int          row;
    hit = 1'b0;
    for (int r = 0; r < rows; r++) begin
      row = row0 + r;
      if (row >= SCREEN_H) break;
      pix = {sh_mem[sh_index[11:0] + 12'(r)], 56'd0} >> col;
      if ((sh_frame[row] & pix) != 0) hit = 1'b1;
      sh_frame[row] ^= pix;
    end
    sh_v[VF_IDX] = {7'd0, hit};
  endfunction

  // one instruction; returns 1 for unknown opcode, 2 for key wait still pending
  function automatic int exec_instr(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
    logic [3:0]  x, y;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  wide;
    int          status;
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    nnn = op[11:0];
    vx = sh_v[x];
    vy = sh_v[y];
    status = 0;
    case (op[15:12])
      OPG_SYS: begin
        if (op == OP_CLS) begin
          foreach (sh_frame[i]) sh_frame[i] = '0;
        end else if (op == OP_RET) begin
          sh_sp = sh_sp - 4'd1;
          sh_pc = sh_stack[sh_sp];
        end
      end
      OPG_JP: sh_pc = nnn;
      OPG_CALL: begin
        sh_stack[sh_sp] = sh_pc;
        sh_sp = sh_sp + 4'd1;
        sh_pc = nnn;
      end
      OPG_SE_IMM:  if (vx == kk) sh_pc += 12'd2;
      OPG_SNE_IMM: if (vx != kk) sh_pc += 12'd2;
      OPG_SE_REG:  if (vx == vy) sh_pc += 12'd2;
      OPG_LD_IMM:  sh_v[x] = kk;
      OPG_ADD_IMM: sh_v[x] = vx + kk;
      OPG_ALU: begin
        case (op[3:0])
          ALU_MOV: sh_v[x] = vy;
          ALU_OR:  sh_v[x] = vx | vy;
          ALU_AND: sh_v[x] = vx & vy;
          ALU_XOR: sh_v[x] = vx ^ vy;
          ALU_ADD: begin
            wide = {1'b0, vx} + {1'b0, vy};
            sh_v[x] = wide[7:0];
            sh_v[VF_IDX] = {7'd0, wide[8]};
          end
          ALU_SUB: begin
            sh_v[x] = vx - vy;
            sh_v[VF_IDX] = {7'd0, vx >= vy};
          end
          ALU_SHR: begin
            sh_v[x] = vx >> 1;
            sh_v[VF_IDX] = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            sh_v[x] = vy - vx;
            sh_v[VF_IDX] = {7'd0, vy >= vx};
          end
          ALU_SHL: begin
            sh_v[x] = vx << 1;
            sh_v[VF_IDX] = {7'd0, vx[7]};
          end
          default: status = 1;
        endcase
      end
      OPG_SNE_REG: if (vx != vy) sh_pc += 12'd2;
      OPG_LD_I:    sh_index = {4'd0, nnn};
      OPG_JP_V0:   sh_pc = nnn + {4'd0, sh_v[0]};
      OPG_RND:     sh_v[x] = rnd & kk;
      OPG_DRW:     draw_sprite(vx[5:0], vy[4:0], op[3:0]);
      OPG_KEY: begin
        if (kk == KEY_SKP) begin
          if (keys[vx[3:0]]) sh_pc += 12'd2;
        end else if (kk == KEY_SKNP) begin
          if (!keys[vx[3:0]]) sh_pc += 12'd2;
        end else begin
          status = 1;
        end
      end
      default: begin
        case (kk)
          MSC_GET_DT: sh_v[x] = sh_delay;
          MSC_WAIT_KEY: begin
            if (keys == 0) begin
              sh_pc -= 12'd2;
              status = 2;
            end else begin
              for (int k = 15; k >= 0; k--) if (keys[k]) sh_v[x] = 8'(k);
            end
          end
          MSC_SET_DT: sh_delay = vx;
          MSC_SET_ST: sh_sound = vx;
          MSC_ADD_I:  sh_index = sh_index + {8'd0, vx};
          MSC_FONT:   sh_index = {4'd0, sh_font_base} + 16'(vx[3:0]) * 16'd5;
          MSC_BCD: begin
            sh_mem[sh_index[11:0]] = vx / 8'd100;
            sh_mem[sh_index[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
            sh_mem[sh_index[11:0] + 12'd2] = vx % 8'd10;
          end
          MSC_STORE: for (int k = 0; k <= x; k++) sh_mem[sh_index[11:0] + 12'(k)] = sh_v[k];
          MSC_LOAD:  for (int k = 0; k <= x; k++) sh_v[k] = sh_mem[sh_index[11:0] + 12'(k)];
          default: status = 1;
        endcase
      end
    endcase
    return status;
  endfunction

  // advance the shadow machine by one item and give the result it must produce
  function automatic result_t step_core(item_t it);
    result_t res;
    int      status;
    res = '{default: '0};
    status = 0;
    case (it.kind)
      OPN_EXEC: begin
        res.opcode = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
        sh_pc += 12'd2;
        status = exec_instr(res.opcode, it.keys, it.rnd);
        if (sh_delay != 0) sh_delay--;
        if (sh_sound != 0) sh_sound--;
      end
      OPN_MEMWR: sh_mem[it.addr] = it.data;
      OPN_ROWRD: res.readv = sh_frame[it.addr[4:0]];
      default:   res.readv = {56'd0, sh_mem[it.addr]};
    endcase
    res.pc = sh_pc;
    res.index = sh_index;
    res.sound = sh_sound != 0;
    res.unknown = status == 1;
    res.waiting = status == 2;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(step_core(pending_items[0]));
        void'(pending_items.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          // some bursts run back to back, others pause a while
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      go = 1'b0;
      if (gap_left > 0) gap_left--;
      else go = pending_items.size() > 0;
      start <= go;
      if (go) begin
        in_operation <= pending_items[0].kind;
        in_address <= pending_items[0].addr;
        in_data_byte <= pending_items[0].data;
        in_keys_down <= pending_items[0].keys;
        in_random_byte <= pending_items[0].rnd;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobe is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_pc_after, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_executed_opcode != want.opcode)
          report_mismatch("executed_opcode", out_executed_opcode, want.opcode);
        if (out_pc_after != want.pc) report_mismatch("pc_after", out_pc_after, want.pc);
        if (out_index_after != want.index)
          report_mismatch("index_after", out_index_after, want.index);
        if (out_read_value != want.readv)
          report_mismatch("read_value", out_read_value, want.readv);
        if (out_sound_on != want.sound) report_mismatch("sound_on", out_sound_on, want.sound);
        if (out_unknown_op != want.unknown)
          report_mismatch("unknown_op", out_unknown_op, want.unknown);
        if (out_key_waiting != want.waiting)
          report_mismatch("key_waiting", out_key_waiting, want.waiting);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(logic [1:0] kind, logic [11:0] addr, logic [7:0] data,
                                      logic [15:0] keys);
    item_t it;
    it.kind = kind;
    it.addr = addr;
    it.data = data;
    it.keys = keys;
    it.rnd = 8'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] random_keys();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed instructions, every group reachable
  function automatic logic [15:0] random_instr();
    logic [15:0] op;
    logic [7:0]  misc [9] = '{MSC_GET_DT, MSC_WAIT_KEY, MSC_SET_DT, MSC_SET_ST, MSC_ADD_I,
                              MSC_FONT, MSC_BCD, MSC_STORE, MSC_LOAD};
    op = 16'($urandom);
    case (op[15:12])
      OPG_SYS: begin
        case ($urandom_range(0, 3))
          0: op = OP_CLS;
          1: op = OP_RET;
          default: ;
        endcase
      end
      OPG_KEY: begin
        case ($urandom_range(0, 4))
          0, 1: op[7:0] = KEY_SKP;
          2, 3: op[7:0] = KEY_SKNP;
          default: ;
        endcase
      end
      OPG_MISC: if ($urandom_range(0, 7) != 0) op[7:0] = misc[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || start) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PROGRAM_START) begin
      sh_prog_start = value;
      sh_pc = value;
    end else begin
      sh_font_base = value;
      load_glyphs();
    end
    @(posedge clk);
  endtask

  task automatic push_word(logic [11:0] addr, logic [15:0] word);
    pending_items.push_back(make_item(OPN_MEMWR, addr, word[15:8], 16'($urandom)));
    pending_items.push_back(make_item(OPN_MEMWR, addr + 12'd1, word[7:0], 16'($urandom)));
  endtask

  // hand-picked program: flag corner cases, clipping, collision, block moves, key skips
  task automatic run_directed();
    logic [15:0] prog [$];
    prog = '{
      {OPG_LD_IMM, 4'hA, 8'hFF}, {OPG_LD_IMM, 4'hB, 8'h01},
      {OPG_ALU, 4'hA, 4'hB, ALU_ADD},          // carry out
      {OPG_ALU, 4'hF, 4'hB, ALU_SUB},          // flag lands on VF itself
      {OPG_ALU, 4'hA, 4'hB, ALU_SUBN}, {OPG_ALU, 4'hB, 4'hA, ALU_SHL},
      {OPG_ALU, 4'hB, 4'hA, ALU_SHR}, {OPG_ALU, 4'hA, 4'hB, 4'h9},
      {OPG_SE_REG, 4'hA, 4'hA, 4'h7},          // low nibble ignored
      {OPG_LD_IMM, 4'h3, 8'hFF}, {OPG_LD_IMM, 4'h4, 8'h3E},
      {OPG_MISC, 4'h3, MSC_FONT},
      {OPG_DRW, 4'h3, 4'h4, 4'hF}, {OPG_DRW, 4'h3, 4'h4, 4'hF},   // clip, then collide
      {OPG_DRW, 4'h3, 4'h4, 4'h0},
      {OPG_LD_I, 12'hFFE}, {OPG_MISC, 4'h3, MSC_BCD},            // wraps memory
      {OPG_MISC, 4'hF, MSC_STORE}, {OPG_MISC, 4'hF, MSC_LOAD},
      {OPG_KEY, 4'h3, KEY_SKP}, {OPG_KEY, 4'h3, KEY_SKNP},
      {OPG_MISC, 4'h0, MSC_WAIT_KEY}, {OPG_MISC, 4'h3, MSC_SET_ST},
      {OPG_MISC, 4'h3, MSC_SET_DT}, {OPG_MISC, 4'h5, MSC_GET_DT},
      {OPG_MISC, 4'h0, 8'h99}, {OPG_KEY, 4'h0, 8'h00}, 16'h0123, OP_CLS,
      {OPG_CALL, 12'h23E}, OP_RET,             // call jumps past the return
      {OPG_JP_V0, 12'hFFF}
    };
    foreach (prog[i]) push_word(sh_prog_start + 12'(2 * i), prog[i]);
    for (int i = 0; i < prog.size() + 6; i++)
      pending_items.push_back(make_item(OPN_EXEC, '0, '0, (i % 3 == 1) ? 16'h8400 : 16'h0));
    pending_items.push_back(make_item(OPN_MEMWR, 12'hFFF, 8'hFF, 16'hFFFF));
    pending_items.push_back(make_item(OPN_MEMRD, 12'hFFF, 8'h00, 16'h0));
    pending_items.push_back(make_item(OPN_ROWRD, 12'h01E, 8'h00, 16'h0));
    pending_items.push_back(make_item(OPN_ROWRD, 12'hFFF, 8'h00, 16'h0));
    wait_idle();
  endtask

  // random instructions patched in at the live program counter, plus noise
  task automatic run_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      wait_drained();
      case ($urandom_range(0, 11))
        0: pending_items.push_back(make_item(OPN_MEMWR, 12'($urandom), 8'($urandom),
                                             random_keys()));
        1: pending_items.push_back(make_item(OPN_ROWRD, 12'($urandom), 8'($urandom),
                                             random_keys()));
        2: pending_items.push_back(make_item(OPN_MEMRD, 12'($urandom), 8'($urandom),
                                             random_keys()));
        3: pending_items.push_back(make_item(OPN_EXEC, 12'($urandom), 8'($urandom),
                                             random_keys()));
        default: begin
          push_word(sh_pc, random_instr());
          pending_items.push_back(make_item(OPN_EXEC, 12'($urandom), 8'($urandom),
                                            random_keys()));
          sent += 2;
        end
      endcase
      sent++;
    end
    wait_idle();
  endtask

  initial begin
    logic [11:0] ps_list [4];
    logic [11:0] fb_list [4];
    ps_list = '{12'd0, 12'd4095, 12'($urandom), 12'(PROG_START_RST)};
    fb_list = '{12'd4015, 12'd0, 12'($urandom_range(0, 4015)), 12'(FONT_BASE_RST)};
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(ITEMS_PER_PHASE / 2);
    for (int p = 0; p < 4; p++) begin
      write_register(REG_PROGRAM_START, ps_list[p]);
      write_register(REG_FONT_BASE, fb_list[p]);
      run_random(ITEMS_PER_PHASE);
    end
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_results.size() != 0)
        $display("MISMATCH %0d results never arrived", expected_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/chip8_pkg.sv
design/chip8_ctrl.sv
design/chip8_dp.sv
design/chip8_instruction_core.sv
dv/tb_chip8_instruction_core.sv
